[src/fxexp_pkg.sv]
`timescale 1ns / 1ps
package fxexp_pkg;

    typedef enum logic [1:0] {
        ACT_CORE = 2'd0,
        ACT_EXP  = 2'd1,
        ACT_DB   = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [0:0] {
        CFG_EXP_LIMIT = 1'b0,
        CFG_DB_LIMIT  = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        POST_CORE,
        POST_SQUARE,
        POST_DOUBLE,
        POST_MAX,
        POST_ZERO
    } t_post;

    typedef struct packed {
        t_post             post;
        logic signed [4:0] e;
        logic [2:0]        idx;
    } t_ctl;

    localparam logic signed [31:0] EXP_LIMIT_RESET = 32'sd1023359280;
    localparam logic signed [31:0] DB_LIMIT_RESET  = 32'sd1107296256;

    localparam logic signed [31:0] INV_LN2_Q30  = 32'sd1549082005;
    localparam logic [31:0]        LN2_Q31      = 32'd1488522236;
    localparam logic signed [24:0] DB_SCALE_Q27 = 25'sd15452387;

    localparam logic [29:0] INV_FACT0 = 30'd715827883;
    localparam logic [27:0] INV_FACT1 = 28'd178956971;
    localparam logic [25:0] INV_FACT2 = 26'd35791394;
    localparam logic [22:0] INV_FACT3 = 23'd5965232;

    localparam logic signed [4:0] TERM_STOP0 = -5'sd10;
    localparam logic signed [4:0] TERM_STOP1 = -5'sd5;
    localparam logic signed [4:0] TERM_STOP2 = 5'sd0;
    localparam logic signed [4:0] TERM_STOP3 = 5'sd6;

    localparam logic [30:0] RESULT_MAX = 31'h7FFFFFFF;

    function automatic logic [31:0] exp_eighth(input logic [2:0] k);
        logic [31:0] v;
        unique case (k)
            3'd0:    v = 32'd2147483648;
            3'd1:    v = 32'd2433417774;
            3'd2:    v = 32'd2757423586;
            3'd3:    v = 32'd3124570271;
            3'd4:    v = 32'd1302514674;
            3'd5:    v = 32'd1475942488;
            3'd6:    v = 32'd1672461947;
            3'd7:    v = 32'd1895147668;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[src/fixed_point_exp_db2lin_core.sv]
`timescale 1ns / 1ps
// Channel   Valid        Ready        Payload
// -------   -----------  -----------  ---------------------------------
// config    i_cfg_we     (none)       i_cfg_idx, i_cfg_data
// input     i_in_valid   o_in_ready   i_action, i_operand
// output    o_out_valid  i_out_ready  o_result
//
// One beat per cycle sustained while the output is not stalled; the pipeline depth
// is set by the chain of dependent multiplies of the Taylor power series.
// Reset is synchronous: it empties the pipeline and loads the limit defaults.
// A stage holds while the stage after it is full and stalled; empty stages are
// filled on the way, so input is taken while a result waits at the output.
module fixed_point_exp_db2lin_core
    import fxexp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_operand,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [30:0]        o_result
);

    localparam int unsigned STAGES   = 16;
    localparam int unsigned ST_SCALE = 0;
    localparam int unsigned ST_SEL   = 1;
    localparam int unsigned ST_MUL   = 2;
    localparam int unsigned ST_EXPN  = 3;
    localparam int unsigned ST_RED   = 4;
    localparam int unsigned ST_P2    = 5;
    localparam int unsigned ST_P3    = 6;
    localparam int unsigned ST_P4    = 7;
    localparam int unsigned ST_P5    = 8;
    localparam int unsigned ST_P6    = 9;
    localparam int unsigned ST_T3    = 10;
    localparam int unsigned ST_SUM   = 11;
    localparam int unsigned ST_TAB   = 12;
    localparam int unsigned ST_SHF   = 13;
    localparam int unsigned ST_SQ    = 14;
    localparam int unsigned ST_OUT   = 15;

    logic signed [31:0] r_exp_lim;
    logic signed [31:0] r_db_lim;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_rdy;

    t_action            r_a_act;
    logic signed [31:0] r_a_opd;
    logic signed [56:0] r_a_dbp;
    logic signed [56:0] n_a_dbp;

    logic signed [31:0] r_x [ST_SEL:ST_EXPN];
    logic signed [31:0] n_b_x;
    logic signed [63:0] r_c_mul;
    logic signed [63:0] n_c_mul;

    t_ctl r_ctl [ST_SEL:ST_SQ];
    t_ctl n_ctl [ST_SEL:ST_SQ];

    logic [28:0] r_bf [ST_RED:ST_P5];
    logic [28:0] n_bf;
    logic [31:0] r_acc [ST_P3:ST_T3];
    logic [31:0] n_acc [ST_P3:ST_T3];

    logic [25:0] r_pw2;
    logic [22:0] r_pw3;
    logic [19:0] r_pw4;
    logic [16:0] r_pw5;
    logic [13:0] r_pw6;
    logic [20:0] r_tk0;
    logic [15:0] r_tk1;
    logic [10:0] r_tk2;
    logic [4:0]  r_tk3;
    logic [31:0] r_expb;
    logic [31:0] r_prod;
    logic [30:0] r_y0 [ST_SHF:ST_SQ];
    logic [61:0] r_sq;
    logic [30:0] r_res;

    logic [31:0] n_expb;
    logic [31:0] n_prod;
    logic [30:0] n_y0;
    logic [61:0] n_sq;
    logic [30:0] n_res;

    logic signed [33:0] w_dbq;
    logic signed [31:0] w_xdb;
    logic signed [31:0] w_xx;
    logic               w_big;
    logic               w_over;
    logic signed [33:0] w_tr;
    logic signed [31:0] w_t;
    logic signed [7:0]  w_eq;
    logic [31:0]        w_elog;
    logic [31:0]        w_y;
    logic [57:0]        w_p2;
    logic [54:0]        w_p3;
    logic [51:0]        w_p4;
    logic [48:0]        w_p5;
    logic [45:0]        w_p6;
    logic [52:0]        w_t0;
    logic [47:0]        w_t1;
    logic [42:0]        w_t2;
    logic [36:0]        w_t3;
    logic [31:0]        w_sum;
    logic [63:0]        w_tab;
    logic signed [5:0]  w_sh6;
    logic [4:0]         w_sh;
    logic [31:0]        w_rnd;
    logic [31:0]        w_rsum;
    logic [31:0]        w_r;
    logic [45:0]        w_sqr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_lim <= EXP_LIMIT_RESET;
            r_db_lim  <= DB_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_EXP_LIMIT: r_exp_lim <= i_cfg_data;
                CFG_DB_LIMIT:  r_db_lim  <= i_cfg_data;
                default:       r_exp_lim <= r_exp_lim;
            endcase
        end
    end

    // a stage may load when the output is ready or any stage from it to the output is empty
    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            w_rdy[k] = i_out_ready
                || ((r_vld | ((STAGES'(1) << k) - STAGES'(1))) != {STAGES{1'b1}});
        end
    end

    assign o_in_ready  = w_rdy[ST_SCALE];
    assign o_out_valid = r_vld[ST_OUT];
    assign o_result    = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (r_vld & ~w_rdy) | ({r_vld[STAGES-2:0], i_in_valid} & w_rdy);
        end
    end

    // scale decibels, pick argument and outcome, split off the power of two and reduce by ln2
    always_comb begin
        n_a_dbp = i_operand * DB_SCALE_Q27;

        w_dbq  = $signed(r_a_dbp[56:23]) + 34'sd1;
        w_xdb  = w_dbq[32:1];
        w_xx   = (r_a_act == ACT_DB) ? w_xdb : r_a_opd;
        w_big  = w_xx[31] ^ w_xx[30];
        w_over = ((r_a_act == ACT_DB) && (r_a_opd > r_db_lim)) || (w_xx > r_exp_lim);
        n_b_x  = ((r_a_act == ACT_CORE) || w_big) ? w_xx : {w_xx[30:0], 1'b0};

        n_ctl[ST_SEL].e   = '0;
        n_ctl[ST_SEL].idx = '0;
        priority if (r_a_act == ACT_CORE) begin
            n_ctl[ST_SEL].post = POST_CORE;
        end else if (r_a_act == ACT_NONE) begin
            n_ctl[ST_SEL].post = POST_ZERO;
        end else if (w_over) begin
            n_ctl[ST_SEL].post = POST_MAX;
        end else if (w_big) begin
            n_ctl[ST_SEL].post = POST_SQUARE;
        end else begin
            n_ctl[ST_SEL].post = POST_DOUBLE;
        end

        for (int k = ST_MUL; k <= ST_SQ; k++) begin
            n_ctl[k] = r_ctl[k-1];
        end

        n_c_mul = r_x[ST_SEL] * INV_LN2_Q30;

        w_tr = $signed(r_c_mul[63:31]) + 34'sd1;
        w_t  = w_tr[32:1];
        w_eq = $signed(w_t[31:25]) + 8'sd1;
        n_ctl[ST_EXPN].e = w_eq[5:1];

        w_elog = {{27{r_ctl[ST_EXPN].e[4]}}, r_ctl[ST_EXPN].e} * LN2_Q31;
        w_y    = {r_x[ST_EXPN][28:0], 3'b000} - w_elog;
        n_ctl[ST_RED].idx = w_y[30:28];
        n_bf   = {w_y[27:0], 1'b0} | 29'h4;
    end

    // Taylor powers and terms
    always_comb begin
        w_p2 = r_bf[ST_RED] * r_bf[ST_RED];
        w_p3 = r_bf[ST_P2] * r_pw2;
        w_p4 = r_bf[ST_P3] * r_pw3;
        w_t0 = r_pw3 * INV_FACT0;
        w_p5 = r_bf[ST_P4] * r_pw4;
        w_t1 = r_pw4 * INV_FACT1;
        w_p6 = r_bf[ST_P5] * r_pw5;
        w_t2 = r_pw5 * INV_FACT2;
        w_t3 = r_pw6 * INV_FACT3;

        n_acc[ST_P3] = 32'(r_bf[ST_P2]) + 32'(r_pw2[25:1]);
        n_acc[ST_P4] = r_acc[ST_P3];
        n_acc[ST_P5] = r_acc[ST_P4]
            + (($signed(r_ctl[ST_P4].e) >= TERM_STOP0) ? 32'(r_tk0) : 32'd0);
        n_acc[ST_P6] = r_acc[ST_P5]
            + (($signed(r_ctl[ST_P5].e) >= TERM_STOP1) ? 32'(r_tk1) : 32'd0);
        n_acc[ST_T3] = r_acc[ST_P6]
            + (($signed(r_ctl[ST_P6].e) >= TERM_STOP2) ? 32'(r_tk2) : 32'd0);

        w_sum  = r_acc[ST_T3]
            + (($signed(r_ctl[ST_T3].e) >= TERM_STOP3) ? 32'(r_tk3) : 32'd0) + 32'd1;
        n_expb = {1'b1, w_sum[31:1]};
    end

    // table scale, rounding shift, squaring, output forming
    always_comb begin
        w_tab  = exp_eighth(r_ctl[ST_SUM].idx) * r_expb;
        n_prod = w_tab[62:31];

        w_sh6  = 6'sd12 - {r_ctl[ST_TAB].e[4], r_ctl[ST_TAB].e};
        w_sh   = w_sh6[4:0];
        w_rnd  = (32'd1 << w_sh) >> 1;
        w_rsum = r_prod + w_rnd;
        w_r    = w_rsum >> w_sh;
        n_y0   = w_r[31] ? RESULT_MAX : w_r[30:0];

        n_sq   = r_y0[ST_SHF] * r_y0[ST_SHF];

        w_sqr  = {1'b0, r_sq[61:17]} + 46'd1;
        unique case (r_ctl[ST_SQ].post)
            POST_CORE:   n_res = r_y0[ST_SQ];
            POST_SQUARE: n_res = (w_sqr[45:32] != '0) ? RESULT_MAX : w_sqr[31:1];
            POST_DOUBLE: n_res = r_y0[ST_SQ][30] ? RESULT_MAX : {r_y0[ST_SQ][29:0], 1'b0};
            POST_MAX:    n_res = RESULT_MAX;
            POST_ZERO:   n_res = '0;
            default:     n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_SCALE]) begin
            r_a_act <= t_action'(i_action);
            r_a_opd <= i_operand;
            r_a_dbp <= n_a_dbp;
        end
        for (int k = ST_SEL; k <= ST_SQ; k++) begin
            if (w_rdy[k]) begin
                r_ctl[k] <= n_ctl[k];
            end
        end
        if (w_rdy[ST_SEL]) begin
            r_x[ST_SEL] <= n_b_x;
        end
        if (w_rdy[ST_MUL]) begin
            r_x[ST_MUL] <= r_x[ST_SEL];
            r_c_mul     <= n_c_mul;
        end
        if (w_rdy[ST_EXPN]) begin
            r_x[ST_EXPN] <= r_x[ST_MUL];
        end
        if (w_rdy[ST_RED]) begin
            r_bf[ST_RED] <= n_bf;
        end
        if (w_rdy[ST_P2]) begin
            r_bf[ST_P2] <= r_bf[ST_RED];
            r_pw2       <= w_p2[57:32];
        end
        if (w_rdy[ST_P3]) begin
            r_bf[ST_P3]  <= r_bf[ST_P2];
            r_pw3        <= w_p3[54:32];
            r_acc[ST_P3] <= n_acc[ST_P3];
        end
        if (w_rdy[ST_P4]) begin
            r_bf[ST_P4]  <= r_bf[ST_P3];
            r_pw4        <= w_p4[51:32];
            r_tk0        <= w_t0[52:32];
            r_acc[ST_P4] <= n_acc[ST_P4];
        end
        if (w_rdy[ST_P5]) begin
            r_bf[ST_P5]  <= r_bf[ST_P4];
            r_pw5        <= w_p5[48:32];
            r_tk1        <= w_t1[47:32];
            r_acc[ST_P5] <= n_acc[ST_P5];
        end
        if (w_rdy[ST_P6]) begin
            r_pw6        <= w_p6[45:32];
            r_tk2        <= w_t2[42:32];
            r_acc[ST_P6] <= n_acc[ST_P6];
        end
        if (w_rdy[ST_T3]) begin
            r_tk3        <= w_t3[36:32];
            r_acc[ST_T3] <= n_acc[ST_T3];
        end
        if (w_rdy[ST_SUM]) begin
            r_expb <= n_expb;
        end
        if (w_rdy[ST_TAB]) begin
            r_prod <= n_prod;
        end
        if (w_rdy[ST_SHF]) begin
            r_y0[ST_SHF] <= n_y0;
        end
        if (w_rdy[ST_SQ]) begin
            r_y0[ST_SQ] <= r_y0[ST_SHF];
            r_sq        <= n_sq;
        end
        if (w_rdy[ST_OUT]) begin
            r_res <= n_res;
        end
    end

endmodule

[src/fxexp_chk.sv]
`timescale 1ns / 1ps
module fxexp_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [30:0]        o_result
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_result))
        else $error("output beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with an empty output stage");

endmodule

bind fixed_point_exp_db2lin_core fxexp_chk u_fxexp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_result    (o_result)
);

[sim/fixed_point_exp_db2lin_core_tb.sv]
`timescale 1ns / 1ps
module fixed_point_exp_db2lin_core_tb;
    import fxexp_pkg::*;

    localparam int PIPE_LATENCY = 24;
    localparam int STALL_LIMIT  = 4000;

    localparam int S32_MAX = 32'sh7FFF_FFFF;
    localparam int S32_MIN = 32'sh8000_0000;

    localparam longint     RECIP_LN2_Q30  = 64'sd1549082005;
    localparam logic [31:0] LN2_Q31_U     = 32'd1488522236;
    localparam int         Q27_MINUS8     = -1073741824;
    localparam int         Q27_PLUS8      = 1073741823;
    localparam longint     DB_TO_NEPER    = 64'sd15452387;
    localparam int         EXP_LIM_DFLT   = 1023359280;
    localparam int         DB_LIM_DFLT    = 1107296256;

    typedef struct {
        t_action act;
        int      opnd;
    } t_exp_arg;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic               i_cfg_idx   = 1'b0;
    logic [31:0]        i_cfg_data  = 32'd0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_action    = 2'd0;
    logic signed [31:0] i_operand   = 32'sd0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [30:0]        o_result;

    t_exp_arg     pending_args[$];
    logic [30:0]  want_results[$];
    int           exp_limit = EXP_LIM_DFLT;
    int           db_limit  = DB_LIM_DFLT;
    int           fail_count = 0;
    int           burst_left = 0;
    int           gap_left   = 0;
    int           quiet_cycles = 0;
    logic [31:0]  rx_cycle = 32'd0;

    logic [31:0]  frac_scale [8];
    logic [31:0]  taylor_coef [4];
    int           taylor_stop [4];

    fixed_point_exp_db2lin_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_operand   (i_operand),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        frac_scale[0] = 32'd2147483648;
        frac_scale[1] = 32'd2433417774;
        frac_scale[2] = 32'd2757423586;
        frac_scale[3] = 32'd3124570271;
        frac_scale[4] = 32'd1302514674;
        frac_scale[5] = 32'd1475942488;
        frac_scale[6] = 32'd1672461947;
        frac_scale[7] = 32'd1895147668;
        taylor_coef[0] = 32'd715827883;
        taylor_coef[1] = 32'd178956971;
        taylor_coef[2] = 32'd35791394;
        taylor_coef[3] = 32'd5965232;
        taylor_stop[0] = -10;
        taylor_stop[1] = -5;
        taylor_stop[2] = 0;
        taylor_stop[3] = 6;
    end

    function automatic longint round_mul(longint a, longint b, int s);
        return (((a * b) >>> s) + 1) >>> 1;
    endfunction

    function automatic logic [31:0] hi_mul(logic [31:0] a, logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[63:32];
    endfunction

    function automatic int sat_word(longint v);
        if (v > longint'(S32_MAX)) return S32_MAX;
        if (v < longint'(S32_MIN)) return S32_MIN;
        return int'(v);
    endfunction

    // e^x, x in Q4.28, result Q13.19
    function automatic logic [31:0] exp_core(int x);
        int          t;
        int          e;
        int          sh;
        logic [31:0] xu;
        logic [31:0] eu;
        logic [31:0] y;
        logic [31:0] bf;
        logic [31:0] pw;
        logic [31:0] base;
        logic [31:0] extra;
        logic [31:0] expb;
        logic [31:0] prod;
        logic [63:0] wide;
        logic        go;
        t = int'(round_mul(x, RECIP_LN2_Q30, 31));
        e = ((t >>> 25) + 1) >>> 1;
        xu = x;
        eu = e;
        y = (xu << 3) - eu * LN2_Q31_U;
        bf = {3'd0, y[27:0], 1'b0} | 32'd4;
        pw = hi_mul(bf, bf);
        base = bf + (pw >> 1);
        extra = 32'd0;
        go = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (e < taylor_stop[k]) go = 1'b0;
            if (go) begin
                pw = hi_mul(bf, pw);
                extra = extra + hi_mul(pw, taylor_coef[k]);
            end
        end
        base = base + extra + 32'd1;
        expb = 32'h8000_0000 + (base >> 1);
        wide = {32'd0, frac_scale[y[30:28]]} * {32'd0, expb};
        prod = wide[62:31];
        sh = 12 - e;
        if (sh < 0) sh = 0;
        if (sh > 31) return 32'd0;
        if (sh > 0) prod = prod + (32'd1 << (sh - 1));
        prod = prod >> sh;
        if (prod > 32'h7FFF_FFFF) prod = 32'h7FFF_FFFF;
        return prod;
    endfunction

    // e^x, x in Q5.27, result Q12.20
    function automatic int exp_q5(int x);
        int y0;
        if (x > exp_limit) return S32_MAX;
        if (x < Q27_MINUS8 || x > Q27_PLUS8) begin
            y0 = exp_core(x);
            return sat_word(round_mul(y0, y0, 17));
        end
        y0 = exp_core(sat_word(longint'(x) * 2));
        return sat_word(longint'(y0) * 2);
    endfunction

    function automatic logic [30:0] predict_gain(t_action act, int opnd);
        int r;
        case (act)
            ACT_CORE: r = exp_core(opnd);
            ACT_EXP:  r = exp_q5(opnd);
            ACT_DB: begin
                if (opnd > db_limit) r = S32_MAX;
                else r = exp_q5(int'(round_mul(opnd, DB_TO_NEPER, 23)));
            end
            default:  r = 0;
        endcase
        if (r < 0) r = 0;
        return 31'(r);
    endfunction

    function automatic int rand_operand(t_action act);
        int v;
        int w;
        int anchor;
        int off;
        case ($urandom_range(0, 3))
            0: v = $urandom();
            1: begin
                w = $urandom_range(1, 31);
                v = $urandom() >> (32 - w);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: begin
                case (act)
                    ACT_EXP: begin
                        case ($urandom_range(0, 3))
                            0: anchor = Q27_MINUS8;
                            1: anchor = Q27_PLUS8;
                            2: anchor = exp_limit;
                            default: anchor = 0;
                        endcase
                    end
                    ACT_DB:  anchor = ($urandom_range(0, 1)) ? db_limit : 0;
                    default: anchor = 0;
                endcase
                off = $urandom() >> $urandom_range(4, 31);
                if ($urandom_range(0, 1)) off = -off;
                v = anchor + off;
            end
        endcase
        return v;
    endfunction

    task automatic queue_arg(t_action act, int opnd);
        t_exp_arg a;
        a.act = act;
        a.opnd = opnd;
        pending_args.push_back(a);
    endtask

    task automatic queue_random(int count);
        t_action act;
        int      pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 15);
            if (pick < 5) act = ACT_CORE;
            else if (pick < 10) act = ACT_EXP;
            else if (pick < 15) act = ACT_DB;
            else act = ACT_NONE;
            queue_arg(act, rand_operand(act));
        end
    endtask

    task automatic wait_drained();
        while (pending_args.size() != 0 || want_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_limit(t_cfg_idx idx, int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_EXP_LIMIT) exp_limit = value;
        else db_limit = value;
    endtask

    task automatic reconfigure(int exp_lim, int db_lim);
        wait_drained();
        write_limit(CFG_EXP_LIMIT, exp_lim);
        write_limit(CFG_DB_LIMIT, db_lim);
        @(negedge i_clk);
    endtask

    function automatic int rand_limit();
        int v;
        if ($urandom_range(0, 1)) v = $urandom();
        else v = Q27_PLUS8 + $urandom_range(0, 1 << 27) - (1 << 26);
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                want_results.push_back(predict_gain(pending_args[0].act, pending_args[0].opnd));
                void'(pending_args.pop_front());
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_args.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_action   <= pending_args[0].act;
                    i_operand  <= pending_args[0].opnd;
                    if (burst_left == 0) burst_left = $urandom_range(1, 24);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        logic [30:0] want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_cycle <= 32'd0;
        end else begin
            rx_cycle <= rx_cycle + 32'd1;
            if (o_out_valid && i_out_ready) begin
                if (want_results.size() == 0) begin
                    $error("result: expected none, actual %0d", o_result);
                    fail_count++;
                end else begin
                    want = want_results.pop_front();
                    if (o_result !== want) begin
                        $error("result: expected %0d, actual %0d", want, o_result);
                        fail_count++;
                    end
                end
            end
            case (rx_cycle[9:8])
                2'd0:    i_out_ready <= 1'b1;
                2'd1:    i_out_ready <= 1'($urandom_range(0, 1));
                2'd2:    i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (rx_cycle[3:0] > 4'd4);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_arg(ACT_CORE, 0);
        queue_arg(ACT_CORE, 268435456);
        queue_arg(ACT_CORE, -268435456);
        queue_arg(ACT_CORE, S32_MAX);
        queue_arg(ACT_CORE, S32_MIN);
        queue_arg(ACT_CORE, 1);
        queue_arg(ACT_CORE, -1);
        queue_arg(ACT_EXP, 0);
        queue_arg(ACT_EXP, Q27_MINUS8);
        queue_arg(ACT_EXP, Q27_MINUS8 - 1);
        queue_arg(ACT_EXP, Q27_PLUS8);
        queue_arg(ACT_EXP, Q27_PLUS8 + 1);
        queue_arg(ACT_EXP, EXP_LIM_DFLT);
        queue_arg(ACT_EXP, EXP_LIM_DFLT + 1);
        queue_arg(ACT_EXP, S32_MIN);
        queue_arg(ACT_EXP, S32_MAX);
        queue_arg(ACT_DB, 0);
        queue_arg(ACT_DB, DB_LIM_DFLT);
        queue_arg(ACT_DB, DB_LIM_DFLT + 1);
        queue_arg(ACT_DB, S32_MIN);
        queue_arg(ACT_DB, -1);
        queue_arg(ACT_NONE, 0);
        queue_arg(ACT_NONE, S32_MAX);
        queue_random(330);

        // open both limits: doubling and squaring can now overflow
        reconfigure(S32_MAX, S32_MAX);
        queue_arg(ACT_EXP, Q27_PLUS8);
        queue_arg(ACT_EXP, 1040000000);
        queue_arg(ACT_EXP, Q27_PLUS8 + 1);
        queue_arg(ACT_EXP, S32_MAX);
        queue_arg(ACT_DB, S32_MAX);
        queue_random(200);

        reconfigure(S32_MIN, S32_MIN);
        queue_arg(ACT_EXP, S32_MIN);
        queue_arg(ACT_DB, S32_MIN);
        queue_arg(ACT_EXP, S32_MIN + 1);
        queue_random(60);

        for (int p = 0; p < 3; p++) begin
            reconfigure(rand_limit(), $urandom());
            queue_random(100);
        end

        reconfigure(EXP_LIM_DFLT, DB_LIM_DFLT);
        queue_random(100);

        wait_drained();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
src/fxexp_pkg.sv
src/fixed_point_exp_db2lin_core.sv
src/fxexp_chk.sv
sim/fixed_point_exp_db2lin_core_tb.sv
